// File: rtl/lu_pkg.sv
// Package for the LU linear system solver: sequencer states and Q-format constants.
// No dependencies.
package lu_pkg;

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_RDA   = 7'b0000010,
      ST_RDB   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_ACC   = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      PH_FACT = 3'b001,
      PH_FWD  = 3'b010,
      PH_BACK = 3'b100
   } phase_type;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage

// File: rtl/lu_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 272
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/lu_div.sv
// Restoring divider for the solver: (a * 2^FRAC_BITS) / d, truncated, saturated.
// Depends on lu_pkg. One quotient bit per cycle.
module lu_div
   import lu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quo
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] q_ff, q_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   dmag_ff, dmag_in;
   logic          neg_ff, neg_in;
   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [33:0]   trial;
   logic [NW:0]   qsigned;
   logic [NW:0]   qmag;

   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, num_ff[NW-1]} - {2'b00, dmag_ff};
      if (go) begin
         num_in  = {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
         dmag_in = den[31] ? 32'(-den) : 32'(den);
         neg_in  = num[31] ^ den[31];
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[NW-1]};
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         num_in = {num_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign done    = busy_ff && cnt_ff == CW'(1);
   // final quotient bit is in q_in during the done cycle
   assign qmag    = {1'b0, q_in};
   assign qsigned = neg_ff ? (NW+1)'(-qmag) : qmag;

   always_comb begin
      if (!neg_ff && qmag > (NW+1)'(SAT_MAX)) quo = SAT_MAX;
      else if (neg_ff && qmag > (NW+1)'(33'h0_8000_0000)) quo = SAT_MIN;
      else quo = qsigned[31:0];
   end

endmodule

// File: rtl/lu_linear_system_solver.sv
// LU linear system solver top level: load, Doolittle factorization, substitution; uses
// lu_pkg, lu_ram and lu_div. A beat loads when start is high and busy low; busy rises after
// the last entry. A multiply-subtract runs through ST_MUL and ST_ACC steps STEP_PROD and
// STEP_MSUB; each element adds reads and writeback, each division a diagonal read and one
// quotient bit per cycle. Results leave one per cycle; the receiver cannot stall.
// Synchronous reset clears sequencer, load count, pivot flag and size (4); stores keep contents.
module lu_linear_system_solver
   import lu_pkg::*;
#(
   parameter int MAX_N     = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_coefficient,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_solution_value,
   output logic [3:0]         rsp_solution_index,
   output logic               rsp_last_of_run,
   output logic               rsp_zero_pivot,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_matrix_size
);

   localparam int STRIDE = MAX_N + 1;
   localparam int DEPTH  = MAX_N * STRIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int IW     = ($clog2(MAX_N + 1) > 4) ? $clog2(MAX_N + 1) : 4;
   localparam int SW     = $clog2(MAX_N);
   localparam int LW     = $clog2(DEPTH + 1);

   // sub-steps of the compute states, kept in c_ff
   localparam logic [IW-1:0] STEP_NONE  = IW'(0);
   localparam logic [IW-1:0] STEP_PROD  = IW'(1);
   localparam logic [IW-1:0] STEP_MSUB  = IW'(2);
   localparam logic [IW-1:0] STEP_DIAG  = IW'(3);
   localparam logic [IW-1:0] STEP_WRITE = IW'(4);
   localparam logic [IW-1:0] STEP_OUT   = IW'(5);

   state_type st_ff, st_in;
   phase_type ph_ff, ph_in;
   logic [4:0]    size_ff;
   logic [IW-1:0] n;
   logic [LW-1:0] lcnt_ff, lcnt_in;
   logic [IW-1:0] r_ff, r_in, c_ff, c_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [31:0] acc_ff, acc_in, opa_ff, opa_in;
   logic signed [63:0] prod_ff;
   logic          fault_ff, fault_in;
   logic          div_go;
   logic          div_done;
   logic signed [31:0] div_quo;
   logic signed [31:0] div_res;
   logic          need_div;
   logic [AW-1:0] m_waddr, m_raddr;
   logic [31:0]   m_wdata, m_rdata;
   logic          m_we;
   logic [SW-1:0] s_waddr, s_raddr;
   logic [31:0]   s_rdata;
   logic          s_we;
   logic          rdsol_ff, rdsol_in;
   logic signed [31:0] rd_val;
   logic signed [64:0] t_full;
   logic signed [64:0] t_shift;
   logic signed [31:0] msub_res;
   logic [IW-1:0] lim;
   logic [IW-1:0] kend;
   logic          load_last;

   always_comb begin
      if (size_ff == 5'd0) n = IW'(1);
      else if (32'(size_ff) > MAX_N) n = IW'(MAX_N);
      else n = IW'(size_ff);
   end

   function automatic logic [AW-1:0] at(input logic [IW-1:0] row,
                                        input logic [IW-1:0] col);
      at = AW'(32'(row) * STRIDE + 32'(col));
   endfunction

   assign csr_ready = (st_ff == ST_LOAD);
   // hold input beats off while a size write is offered
   assign busy      = (st_ff != ST_LOAD) || csr_valid;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= 5'd4;
      else if (csr_valid && csr_ready) size_ff <= csr_matrix_size;
   end

   lu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mat (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_addr(m_raddr), .rd_data(m_rdata)
   );
   lu_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_sol (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(div_res),
      .rd_addr(s_raddr), .rd_data(s_rdata)
   );
   lu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(acc_ff), .den(rd_val),
      .done(div_done), .quo(div_quo)
   );

   assign rd_val = rdsol_ff ? $signed(s_rdata) : $signed(m_rdata);

   // a*2^F - b*c + half, floor shift, saturate
   assign t_full  = ($signed(65'(acc_ff)) <<< FRAC_BITS) - 65'(prod_ff)
                  + (65'sd1 <<< (FRAC_BITS - 1));
   assign t_shift = t_full >>> FRAC_BITS;
   always_comb begin
      if (t_shift > 65'(SAT_MAX)) msub_res = SAT_MAX;
      else if (t_shift < 65'(SAT_MIN)) msub_res = SAT_MIN;
      else msub_res = t_shift[31:0];
   end

   assign load_last = (lcnt_ff + 1'b1) == LW'(32'(n) * (32'(n) + 1));
   assign lim  = (j_ff < i_ff) ? j_ff : i_ff;
   assign need_div = (ph_ff == PH_FACT && j_ff < i_ff) || ph_ff == PH_BACK;
   // zero divisor and no-division paths write the accumulator
   assign div_res  = (c_ff == STEP_WRITE) ? acc_ff : div_quo;
   // inner loop end per phase
   always_comb begin
      unique case (ph_ff)
         PH_FACT: kend = lim;
         PH_FWD:  kend = i_ff;
         PH_BACK: kend = n;
         default: kend = '0;
      endcase
   end

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; lcnt_in = lcnt_ff;
      r_in = r_ff; c_in = c_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      acc_in = acc_ff; opa_in = opa_ff; fault_in = fault_ff; rdsol_in = 1'b0;
      m_we = 1'b0; m_waddr = at(r_ff, c_ff); m_wdata = req_coefficient;
      m_raddr = '0; s_we = 1'b0; s_waddr = SW'(i_ff); s_raddr = SW'(k_ff);
      div_go = 1'b0;
      rsp_valid = 1'b0;
      unique case (st_ff)
         ST_LOAD: begin
            if (csr_valid) begin
               lcnt_in = '0; r_in = '0; c_in = '0;
            end else if (start) begin
               m_we = 1'b1;
               if (c_ff == n) begin
                  c_in = '0; r_in = r_ff + 1'b1;
               end else c_in = c_ff + 1'b1;
               lcnt_in = lcnt_ff + 1'b1;
               if (load_last) begin
                  lcnt_in = '0; r_in = '0; c_in = STEP_NONE; fault_in = 1'b0;
                  // start factorization at row 1 (or skip to forward)
                  if (n == IW'(1)) begin
                     ph_in = PH_FWD; i_in = '0;
                  end else begin
                     ph_in = PH_FACT; i_in = IW'(1);
                  end
                  j_in = '0; k_in = '0;
                  st_in = ST_RDA;
               end
            end
         end
         // read target element into acc
         ST_RDA: begin
            unique case (ph_ff)
               PH_FACT: m_raddr = at(i_ff, j_ff);
               default: m_raddr = at(i_ff, n);
            endcase
            if (ph_ff == PH_BACK) k_in = i_ff + 1'b1;
            else k_in = '0;
            st_in = ST_RDB;
            opa_in = 32'sd0;
         end
         // read operand b (row i, col k), or route to divide / store
         ST_RDB: begin
            acc_in = rd_val;
            if (k_ff == kend) begin
               // no product terms
               st_in = ST_ACC;
               m_raddr = at(j_ff, j_ff);
               if (ph_ff == PH_BACK) m_raddr = at(i_ff, i_ff);
            end else begin
               m_raddr = at(i_ff, k_ff);
               st_in = ST_MUL;
            end
         end
         default: ;
      endcase
      // the remaining states are handled below
      unique case (st_ff)
         ST_MUL: begin
            // rd_val is row element; fetch partner
            opa_in = rd_val;
            if (ph_ff == PH_FACT) m_raddr = at(k_ff, j_ff);
            else if (ph_ff == PH_FWD) m_raddr = at(k_ff, n);
            else begin
               s_raddr = SW'(k_ff); rdsol_in = 1'b1;
            end
            st_in = ST_ACC;
            k_in = k_ff;
            c_in = STEP_PROD;
         end
         ST_ACC: begin
            if (c_ff == STEP_PROD) begin
               // rd_val is partner; the product is registered for the next step
               c_in = STEP_MSUB;
            end else if (c_ff == STEP_MSUB) begin
               acc_in = msub_res;
               c_in = STEP_NONE;
               k_in = k_ff + 1'b1;
               if (k_ff + 1'b1 == kend) begin
                  st_in = ST_DIV; c_in = STEP_DIAG;
                  if (ph_ff == PH_FACT) m_raddr = at(j_ff, j_ff);
                  else m_raddr = at(i_ff, i_ff);
               end else begin
                  m_raddr = at(i_ff, k_ff + 1'b1);
                  st_in = ST_MUL;
               end
            end else begin
               // no-term path: diag read issued last cycle
               st_in = ST_DIV; c_in = STEP_DIAG;
               if (ph_ff == PH_FACT) m_raddr = at(j_ff, j_ff);
               else m_raddr = at(i_ff, i_ff);
            end
         end
         ST_DIV: begin
            if (c_ff == STEP_DIAG) begin
               c_in = STEP_NONE;
               if (need_div) begin
                  if (rd_val == 32'sd0) begin
                     fault_in = 1'b1;
                     acc_in = 32'sd0;
                     c_in = STEP_WRITE;
                  end else div_go = 1'b1;
               end else c_in = STEP_WRITE;
            end else if (c_ff == STEP_WRITE || div_done) begin
               c_in = STEP_NONE;
               // writeback
               if (ph_ff == PH_BACK) begin
                  s_we = 1'b1; s_waddr = SW'(i_ff);
               end else begin
                  m_we = 1'b1;
                  m_wdata = div_res;
                  m_waddr = (ph_ff == PH_FACT) ? at(i_ff, j_ff) : at(i_ff, n);
               end
               st_in = ST_RDA;
               unique case (ph_ff)
                  PH_FACT: begin
                     if (j_ff == n - 1'b1) begin
                        j_in = '0;
                        if (i_ff == n - 1'b1) begin
                           ph_in = PH_FWD; i_in = '0;
                        end else i_in = i_ff + 1'b1;
                     end else j_in = j_ff + 1'b1;
                  end
                  PH_FWD: begin
                     if (i_ff == n - 1'b1) ph_in = PH_BACK;
                     else i_in = i_ff + 1'b1;
                  end
                  default: begin
                     if (i_ff == '0) begin
                        st_in = ST_EMIT; k_in = '0;
                     end else i_in = i_ff - 1'b1;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // read sol[k], present next cycle
            s_raddr = SW'(k_ff);
            if (c_ff == STEP_OUT) begin
               rsp_valid = 1'b1;
               if (k_ff == n) begin
                  st_in = ST_LOAD; c_in = '0;
               end
            end
            if (k_ff != n) begin
               k_in = k_ff + 1'b1; c_in = STEP_OUT;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; ph_ff <= PH_FACT; lcnt_ff <= '0;
         r_ff <= '0; c_ff <= '0; fault_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; lcnt_ff <= lcnt_in;
         r_ff <= r_in; c_ff <= c_in; fault_ff <= fault_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      acc_ff <= acc_in; opa_ff <= opa_in; rdsol_ff <= rdsol_in;
      prod_ff <= opa_ff * rd_val;
   end

   logic [IW-1:0] oidx;
   assign oidx = k_ff - 1'b1;
   assign rsp_solution_value = $signed(s_rdata);
   assign rsp_solution_index = oidx[3:0];
   assign rsp_last_of_run    = (k_ff == n);
   assign rsp_zero_pivot     = fault_ff;

endmodule

// File: tb/sv/lu_linear_system_solver_tb.sv
`timescale 1ns / 1ps
// Testbench for lu_linear_system_solver: loads augmented systems, predicts x in Q16.16
// and checks every solution beat. Depends on lu_pkg and the solver RTL only.
module lu_linear_system_solver_tb
   import lu_pkg::*;
();

   localparam int MAX_N = 16;
   localparam int FRAC  = 16;

   typedef struct {
      logic signed [31:0] value;
      logic [3:0]         index;
      logic               last;
      logic               fault;
   } solution_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic signed [31:0] req_coefficient = '0;
   logic               csr_valid = 1'b0;
   logic [4:0]         csr_matrix_size = '0;
   logic               busy, rsp_valid, rsp_last_of_run, rsp_zero_pivot, csr_ready;
   logic signed [31:0] rsp_solution_value;
   logic [3:0]         rsp_solution_index;

   lu_linear_system_solver #(.MAX_N(MAX_N), .FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coefficient(req_coefficient),
      .rsp_valid(rsp_valid), .rsp_solution_value(rsp_solution_value),
      .rsp_solution_index(rsp_solution_index), .rsp_last_of_run(rsp_last_of_run),
      .rsp_zero_pivot(rsp_zero_pivot),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_matrix_size(csr_matrix_size)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pending coefficients and expected solution beats
   logic signed [31:0] coefficient_q[$];
   solution_type       solution_q[$];

   // predictor state
   logic [4:0]         size_reg = 5'd4;
   int                 load_count = 0;
   logic signed [31:0] mat [MAX_N][MAX_N+1];
   logic signed [31:0] sol [MAX_N];
   bit                 pivot_fault = 0;

   int  error_count = 0;
   int  runs_solved = 0;
   int  fault_runs = 0;
   int  beats_checked = 0;
   int  items_taken = 0;
   int  gap_left = 0;
   bit  no_idle = 0;
   bit  beat_taken = 0;

   task automatic report(input string msg);
      error_count++;
      $display("ERROR %0t: %s", $time, msg);
   endtask

   function automatic logic signed [31:0] saturate(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return SAT_MAX;
      if (v < -longint'(64'd2147483648)) return SAT_MIN;
      return v[31:0];
   endfunction

   // a - b*c, one rounding: half up, floor shift
   function automatic logic signed [31:0] mul_sub_q(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input logic signed [31:0] c);
      longint t;
      t = (longint'(a) <<< FRAC) - longint'(b) * longint'(c)
        + (longint'(1) <<< (FRAC - 1));
      return saturate(t >>> FRAC);
   endfunction

   function automatic logic signed [31:0] div_q(input logic signed [31:0] a,
                                                input logic signed [31:0] d);
      if (d == 0) begin
         pivot_fault = 1;
         return '0;
      end
      return saturate((longint'(a) <<< FRAC) / longint'(d));
   endfunction

   function automatic int active_size(input logic [4:0] sz);
      if (sz == 0) return 1;
      if (sz > MAX_N) return MAX_N;
      return sz;
   endfunction

   function automatic void solve_system(input int n);
      int lim;
      logic signed [31:0] acc;
      pivot_fault = 0;
      for (int i = 1; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            lim = (j < i) ? j : i;
            for (int k = 0; k < lim; k++)
               mat[i][j] = mul_sub_q(mat[i][j], mat[i][k], mat[k][j]);
            if (j < i) mat[i][j] = div_q(mat[i][j], mat[j][j]);
         end
      end
      for (int i = 0; i < n; i++) begin
         acc = mat[i][n];
         for (int k = 0; k < i; k++) acc = mul_sub_q(acc, mat[i][k], mat[k][n]);
         mat[i][n] = acc;
      end
      for (int i = n - 1; i >= 0; i--) begin
         acc = mat[i][n];
         for (int k = i + 1; k < n; k++) acc = mul_sub_q(acc, mat[i][k], sol[k]);
         sol[i] = div_q(acc, mat[i][i]);
      end
   endfunction

   function automatic void take_coefficient(input logic signed [31:0] coef);
      int n, cols;
      solution_type s;
      n = active_size(size_reg);
      cols = n + 1;
      if (load_count >= n * cols) load_count = 0;
      mat[load_count / cols][load_count % cols] = coef;
      load_count++;
      if (load_count < n * cols) return;
      load_count = 0;
      solve_system(n);
      runs_solved++;
      if (pivot_fault) fault_runs++;
      for (int i = 0; i < n; i++) begin
         s.value = sol[i];
         s.index = i[3:0];
         s.last  = (i == n - 1);
         s.fault = pivot_fault;
         solution_q.push_back(s);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: hold a beat until taken, then idle or advance
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !beat_taken) begin
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (coefficient_q.size() > 0) begin
         start <= 1'b1;
         req_coefficient <= coefficient_q.pop_front();
         gap_left = pick_gap();
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: sample at the rising edge
   always @(posedge clock) begin
      solution_type e;
      beat_taken = 0;
      if (!reset) begin
         if (rsp_valid) begin
            beats_checked++;
            if (solution_q.size() == 0) begin
               report($sformatf("unexpected result index %0d", rsp_solution_index));
            end else begin
               e = solution_q.pop_front();
               if (rsp_solution_value !== e.value)
                  report($sformatf("x%0d value %h, want %h", e.index,
                                   rsp_solution_value, e.value));
               if (rsp_solution_index !== e.index)
                  report($sformatf("index %0d, want %0d", rsp_solution_index, e.index));
               if (rsp_last_of_run !== e.last)
                  report($sformatf("x%0d last %b, want %b", e.index, rsp_last_of_run,
                                   e.last));
               if (rsp_zero_pivot !== e.fault)
                  report($sformatf("x%0d zero_pivot %b, want %b", e.index, rsp_zero_pivot,
                                   e.fault));
            end
         end
         if (start && !busy) begin
            beat_taken = 1;
            items_taken++;
            take_coefficient(req_coefficient);
         end
      end
   end

   task automatic wait_idle();
      while (coefficient_q.size() > 0 || start || solution_q.size() > 0) @(negedge clock);
      repeat (64) @(negedge clock);
   endtask

   task automatic write_size(input logic [4:0] sz);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_matrix_size <= sz;
      do @(posedge clock); while (!csr_ready);
      size_reg = sz;
      load_count = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
      no_idle = ($urandom_range(0, 3) == 0);
   endtask

   // style 0: well conditioned, 1: zero leading pivot, 2: full-range noise
   task automatic queue_system(input int n, input int style);
      logic signed [31:0] v;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c <= n; c++) begin
            v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            if (r == c)
               v = v + (($urandom_range(0, 1) != 0) ? 32'sh0008_0000 : -32'sh0008_0000);
            if (style == 2 || $urandom_range(0, 39) == 0) v = $urandom;
            if (style == 1 && r == 0 && c == 0) v = '0;
            coefficient_q.push_back(v);
         end
      end
   endtask

   initial begin
      int sz, items;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default size, then single-unknown extremes
      queue_system(4, 0);
      wait_idle();
      write_size(5'd0);
      coefficient_q = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF,
                        32'sh0000_0000, 32'sh0001_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'shFFFF_FFFF, 32'sh8000_0000};
      wait_idle();
      // drop a partial load by rewriting the size
      write_size(5'd3);
      queue_system(3, 0);
      coefficient_q = coefficient_q[0:4];
      wait_idle();
      write_size(5'd2);
      queue_system(2, 1);
      wait_idle();
      // oversize setting acts as the largest system: this partial load completes nothing
      write_size(5'd31);
      for (int s = 0; s < 30; s++) coefficient_q.push_back($urandom);
      wait_idle();

      while (items_taken < 280) begin
         sz = $urandom_range(0, 6);
         if ($urandom_range(0, 11) == 0) sz = $urandom_range(7, 10);
         write_size(sz[4:0]);
         for (int s = $urandom_range(1, 2); s > 0; s--) begin
            items = active_size(sz[4:0]);
            queue_system(items, ($urandom_range(0, 9) == 0) ? 1 :
                                ($urandom_range(0, 9) == 0) ? 2 : 0);
         end
         // occasionally leave a broken partial load behind
         if ($urandom_range(0, 5) == 0) coefficient_q.push_back($urandom);
         wait_idle();
      end

      $display("loaded %0d coefficients, solved %0d systems (%0d with a zero pivot)",
               items_taken, runs_solved, fault_runs);
      $display("checked %0d solution beats across random sizes and size rewrites",
               beats_checked);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
